FILE: src/sfr_pkg.sv
// Package for the stream find-and-replace block: word types, register
// indexes and shared constants. No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int MAX_PATTERN_DEFAULT = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BYTES      = 3'd0,
        REG_PATTERN_LENGTH     = 3'd1,
        REG_REPLACEMENT_BYTES  = 3'd2,
        REG_REPLACEMENT_LENGTH = 3'd3,
        REG_MAX_OUTPUT         = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_output;
    } out_word_t;

    // Controls shared by every window cell.
    typedef struct packed {
        logic step;
        logic shift;
    } win_ctl_t;

    // Controls shared by every burst buffer cell.
    typedef struct packed {
        logic load;
        logic shift;
    } burst_ctl_t;

endpackage

FILE: src/stream_find_replace.sv
// Top level of the stream find-and-replace block: configuration registers,
// window cell chain and match control. Depends on sfr_pkg, sfr_win_cell, sfr_emitter.
`timescale 1ns / 1ps

// Usage:
// Text enters on the s_ channel, one byte per word with an end-of-text flag.
// Results leave on the m_ channel: a byte, a has_byte flag and an end flag on
// the last word of a text. A text whose output is empty ends with one bare
// word (has_byte low). Registers are written through cfg_we, cfg_index and
// cfg_data while the block is idle; writing the pattern length drops any
// bytes held in the window.
// Each input word is compared against the whole pattern at once across the
// row of window cells; the words it causes load into the burst buffer at once
// and the first appears in the cycle after the word is accepted. A word making
// at most one result lets the next word in at once while the receiver keeps
// up; a word making N results (a replacement, or a flush at end of text) holds
// the input while the burst buffer drains, one word per cycle if not stalled.
// When the receiver stalls, the current result holds and input is refused
// until the last word of the burst is leaving in the same cycle.
// Synchronous reset clears the fill count, the output counter, the word count
// of the burst buffer and the configuration registers to their reset values;
// the window and burst cell bytes are not reset, and no clearing pass is needed.

module stream_find_replace #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  sfr_pkg::in_word_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output sfr_pkg::out_word_t                 m_data,
    input  logic                               cfg_we,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sfr_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic [63:0] pattern_reg;
    logic [3:0]  plen_reg;
    logic [63:0] repl_reg;
    logic [3:0]  rlen_reg;
    logic [15:0] max_reg;
    logic [LW-1:0] fill_reg, fill_next;
    logic [15:0]   count_reg, count_next;

    logic [LW-1:0] plen_c, rlen_c, fill1, k, n;
    logic [15:0]   room;
    logic          step, last, full, match, bare;
    logic [MAX_PATTERN-1:0]      eq;
    logic [MAX_PATTERN-1:0][7:0] cur;
    logic [MAX_PATTERN-1:0][7:0] src;
    win_ctl_t      wctl;

    // Lengths saturate to the window depth; a zero pattern length acts as one.
    always_comb begin
        if (plen_reg == 4'd0) begin
            plen_c = LW'(1);
        end else if (plen_reg > 4'(MAX_PATTERN)) begin
            plen_c = LW'(MAX_PATTERN);
        end else begin
            plen_c = LW'(plen_reg);
        end
        if (rlen_reg > 4'(MAX_PATTERN)) begin
            rlen_c = LW'(MAX_PATTERN);
        end else begin
            rlen_c = LW'(rlen_reg);
        end
    end

    assign step  = s_valid && s_ready;
    assign last  = s_data.end_of_input;
    assign fill1 = fill_reg + LW'(1);
    assign full  = (fill1 == plen_c);
    assign match = full && (&eq);

    assign wctl.step  = step;
    assign wctl.shift = full && !match && !last;

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_win
        logic [7:0] nbr;
        if (i == MAX_PATTERN - 1) begin : g_tail
            assign nbr = 8'h00;
        end else begin : g_mid
            assign nbr = cur[i+1];
        end
        sfr_win_cell u_cell (
            .aclk     (aclk),
            .ctl      (wctl),
            .sel      (fill_reg == LW'(i)),
            .in_use   (LW'(i) < plen_c),
            .in_byte  (s_data.text_byte),
            .nbr_byte (nbr),
            .pat_byte (pattern_reg[8*i +: 8]),
            .cur_byte (cur[i]),
            .eq       (eq[i])
        );
        assign src[i] = match ? repl_reg[8*i +: 8] : cur[i];
    end

    // Burst size: the replacement on a match, otherwise the oldest byte on a
    // full window, or the whole window when the text ends; then limited to the room left under the maximum output.
    always_comb begin
        if (match) begin
            k = rlen_c;
        end else if (last) begin
            k = fill1;
        end else if (full) begin
            k = LW'(1);
        end else begin
            k = '0;
        end
        room = (count_reg < max_reg) ? (max_reg - count_reg) : 16'd0;
        n    = (room < 16'(k)) ? LW'(room) : k;
        bare = last && (n == '0);
    end

    always_comb begin
        fill_next  = fill_reg;
        count_next = count_reg;
        if (step) begin
            if (last || match) begin
                fill_next = '0;
            end else if (full) begin
                fill_next = plen_c - LW'(1);
            end else begin
                fill_next = fill1;
            end
            count_next = last ? 16'd0 : (count_reg + 16'(n));
        end
        if (cfg_we && (cfg_index == REG_PATTERN_LENGTH)) begin
            fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            plen_reg    <= 4'd1;
            repl_reg    <= '0;
            rlen_reg    <= 4'd0;
            max_reg     <= 16'hFFFF;
            fill_reg    <= '0;
            count_reg   <= '0;
        end else begin
            fill_reg  <= fill_next;
            count_reg <= count_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_PATTERN_BYTES:      pattern_reg <= cfg_data;
                    REG_PATTERN_LENGTH:     plen_reg    <= cfg_data[3:0];
                    REG_REPLACEMENT_BYTES:  repl_reg    <= cfg_data;
                    REG_REPLACEMENT_LENGTH: rlen_reg    <= cfg_data[3:0];
                    REG_MAX_OUTPUT:         max_reg     <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    sfr_emitter #(
        .DEPTH (MAX_PATTERN)
    ) u_emitter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (step),
        .load_count    (bare ? LW'(1) : n),
        .load_has_byte (!bare),
        .load_end      (last),
        .src_bytes     (src),
        .in_ready      (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

    // The window never holds a full pattern between words.
    a_fill_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < plen_c)
        else $error("window fill reached the pattern length");

    // Every text ends with at least one result.
    a_end_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        step && last |=> m_valid)
        else $error("end of text produced no result");

    // An empty burst buffer always takes input.
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input refused with nothing pending");

    // The end flag leaves the counter and the window fill cleared for the next text.
    a_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        step && last |=> count_reg == 16'd0 && fill_reg == '0)
        else $error("state not cleared after end of text");

endmodule

FILE: src/sfr_win_cell.sv
// One window cell: holds one text byte, compares it with its pattern byte.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_win_cell (
    input  logic            aclk,
    input  sfr_pkg::win_ctl_t ctl,
    input  logic            sel,
    input  logic            in_use,
    input  logic [7:0]      in_byte,
    input  logic [7:0]      nbr_byte,
    input  logic [7:0]      pat_byte,
    output logic [7:0]      cur_byte,
    output logic            eq
);
    import sfr_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // The cell at the fill position sees the arriving byte this cycle.
    assign cur_byte = sel ? in_byte : byte_reg;
    assign eq = !in_use || (cur_byte == pat_byte);

    always_comb begin
        byte_next = byte_reg;
        if (ctl.step) begin
            if (ctl.shift) begin
                byte_next = nbr_byte;
            end else if (sel) begin
                byte_next = in_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule

FILE: src/sfr_burst_cell.sv
// One cell of the output burst buffer; cells shift toward the output port.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_burst_cell (
    input  logic                aclk,
    input  sfr_pkg::burst_ctl_t ctl,
    input  logic [7:0]          ld_byte,
    input  logic [7:0]          nbr_byte,
    output logic [7:0]          q_byte
);
    import sfr_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign q_byte = byte_reg;

    always_comb begin
        byte_next = byte_reg;
        if (ctl.load) begin
            byte_next = ld_byte;
        end else if (ctl.shift) begin
            byte_next = nbr_byte;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule

FILE: src/sfr_emitter.sv
// Output stage: a row of burst cells drained one word per handshake.
// Depends on sfr_pkg and sfr_burst_cell.
`timescale 1ns / 1ps

module sfr_emitter #(
    parameter int DEPTH = sfr_pkg::MAX_PATTERN_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  logic [$clog2(DEPTH+1)-1:0]     load_count,
    input  logic                           load_has_byte,
    input  logic                           load_end,
    input  logic [DEPTH-1:0][7:0]          src_bytes,
    output logic                           in_ready,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sfr_pkg::out_word_t             m_data
);
    import sfr_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] rem_reg, rem_next;
    logic          end_reg, end_next;
    logic          has_reg, has_next;
    logic          take;
    burst_ctl_t    cctl;
    logic [DEPTH-1:0][7:0] q;

    assign m_valid  = (rem_reg != '0);
    assign take     = m_valid && m_ready;
    // A new burst may load while the final word of the old one leaves.
    assign in_ready = (rem_reg == '0) || ((rem_reg == CW'(1)) && m_ready);

    assign cctl.load  = load;
    assign cctl.shift = take;

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        logic [7:0] nbr;
        if (j == DEPTH - 1) begin : g_tail
            assign nbr = 8'h00;
        end else begin : g_mid
            assign nbr = q[j+1];
        end
        sfr_burst_cell u_cell (
            .aclk     (aclk),
            .ctl      (cctl),
            .ld_byte  (src_bytes[j]),
            .nbr_byte (nbr),
            .q_byte   (q[j])
        );
    end

    always_comb begin
        rem_next = rem_reg;
        end_next = end_reg;
        has_next = has_reg;
        if (load) begin
            rem_next = load_count;
            end_next = load_end;
            has_next = load_has_byte;
        end else if (take) begin
            rem_next = rem_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            end_reg <= 1'b0;
            has_reg <= 1'b0;
        end else begin
            rem_reg <= rem_next;
            end_reg <= end_next;
            has_reg <= has_next;
        end
    end

    assign m_data.out_byte      = has_reg ? q[0] : 8'h00;
    assign m_data.has_byte      = has_reg;
    assign m_data.end_of_output = end_reg && (rem_reg == CW'(1));

endmodule
